>>> src/assert_macros.svh
// Assertion macros used by the time-of-day clock RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TOD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TOD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/tod_pkg.sv
// Types, codes and helper functions of the time-of-day clock.
`timescale 1ns / 1ps
`default_nettype none

package tod_pkg;

   localparam int unsigned FLAG_COUNT = 5;
   localparam int unsigned ALARM_BIT  = 2;
   localparam int unsigned FLAG_BIT   = 4;

   localparam logic [FLAG_COUNT-1:0] ALARM_SOURCE = FLAG_COUNT'(1) << ALARM_BIT;
   localparam logic [FLAG_COUNT-1:0] FLAG_SOURCE  = FLAG_COUNT'(1) << FLAG_BIT;

   typedef enum logic [1:0] {
      CMD_TICK       = 2'd0,
      CMD_SET_TIME   = 2'd1,
      CMD_SET_ALARM  = 2'd2,
      CMD_PIN_SAMPLE = 2'd3
   } command_type;

   typedef enum logic {
      REG_ALARM_ENABLE   = 1'b0,
      REG_INTERRUPT_MASK = 1'b1
   } reg_index_type;

   typedef struct packed {
      command_type command;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [3:0]  tenth;
      logic        pin_level;
   } item_type;

   typedef struct packed {
      logic [5:0]            hour_bcd;
      logic [6:0]            minute_bcd;
      logic [6:0]            second_bcd;
      logic [4:0]            tenth_bcd;
      logic [FLAG_COUNT-1:0] pending_flags;
      logic                  irq;
   } result_type;

   typedef struct packed {
      logic                  alarm_enable;
      logic [FLAG_COUNT-1:0] interrupt_mask;
   } cfg_type;

   // Binary 0..63 to two BCD digits; the tens digit is found by a short compare chain.
   function automatic logic [6:0] to_bcd(input logic [5:0] value);
      logic [2:0] tens;
      logic [5:0] ones;
      tens = 3'd0;
      for (int k = 1; k <= 6; k++) begin
         if (value >= 6'(k * 10)) begin
            tens = 3'(k);
         end
      end
      ones = value - 6'({3'd0, tens} * 6'd10);
      return {tens, ones[3:0]};
   endfunction

endpackage

`default_nettype wire

>>> src/tod_csr.sv
// Configuration registers: alarm enable and interrupt mask.
`timescale 1ns / 1ps
`default_nettype none

module tod_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic                          csr_index,
   input  wire logic [tod_pkg::FLAG_COUNT-1:0] csr_data,
   output tod_pkg::cfg_type                   cfg
);
   import tod_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_ALARM_ENABLE:   cfg_in.alarm_enable   = csr_data[0];
            REG_INTERRUPT_MASK: cfg_in.interrupt_mask = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> src/tod_core.sv
// Time, alarm and interrupt-flag state with the per-transaction update logic.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tod_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire tod_pkg::item_type item,
   input  wire tod_pkg::cfg_type  cfg,
   output tod_pkg::result_type result
);
   import tod_pkg::*;

   logic [4:0] time_hours_ff, time_hours_in;
   logic [5:0] time_minutes_ff, time_minutes_in;
   logic [5:0] time_seconds_ff, time_seconds_in;
   logic [3:0] time_tenths_ff, time_tenths_in;
   logic [4:0] alarm_hours_ff, alarm_hours_in;
   logic [5:0] alarm_minutes_ff, alarm_minutes_in;
   logic [5:0] alarm_seconds_ff, alarm_seconds_in;
   logic [3:0] alarm_tenths_ff, alarm_tenths_in;
   logic [FLAG_COUNT-1:0] flags_ff, flags_in;
   logic prev_pin_ff, prev_pin_in;

   always_comb begin
      logic [4:0] inc_tenth;
      logic [6:0] inc_second;
      logic [6:0] inc_minute;
      logic [5:0] inc_hour;
      logic       alarm_match;
      logic [FLAG_COUNT-1:0] raise;
      logic [6:0] hour_digits;
      logic [6:0] minute_digits;
      logic [6:0] second_digits;
      logic [6:0] tenth_digits;

      time_hours_in    = time_hours_ff;
      time_minutes_in  = time_minutes_ff;
      time_seconds_in  = time_seconds_ff;
      time_tenths_in   = time_tenths_ff;
      alarm_hours_in   = alarm_hours_ff;
      alarm_minutes_in = alarm_minutes_ff;
      alarm_seconds_in = alarm_seconds_ff;
      alarm_tenths_in  = alarm_tenths_ff;
      prev_pin_in      = prev_pin_ff;
      raise            = '0;
      alarm_match      = 1'b0;

      inc_tenth  = {1'b0, time_tenths_ff} + 5'd1;
      inc_second = {1'b0, time_seconds_ff} + 7'd1;
      inc_minute = {1'b0, time_minutes_ff} + 7'd1;
      inc_hour   = {1'b0, time_hours_ff} + 6'd1;

      unique case (item.command)
         CMD_TICK: begin
            // A digit that carries out wraps to zero, even when it was set out of range.
            if (inc_tenth >= 5'd10) begin
               time_tenths_in = 4'd0;
               if (inc_second >= 7'd60) begin
                  time_seconds_in = 6'd0;
                  if (inc_minute >= 7'd60) begin
                     time_minutes_in = 6'd0;
                     time_hours_in   = (inc_hour >= 6'd24) ? 5'd0 : inc_hour[4:0];
                  end else begin
                     time_minutes_in = inc_minute[5:0];
                  end
               end else begin
                  time_seconds_in = inc_second[5:0];
               end
            end else begin
               time_tenths_in = inc_tenth[3:0];
            end
            alarm_match = (time_tenths_in == alarm_tenths_ff)
                       && (time_seconds_in == alarm_seconds_ff)
                       && (time_minutes_in == alarm_minutes_ff)
                       && (time_hours_in == alarm_hours_ff);
            if (cfg.alarm_enable && alarm_match) begin
               raise = ALARM_SOURCE;
            end
         end
         CMD_SET_TIME: begin
            time_hours_in   = item.hour;
            time_minutes_in = item.minute;
            time_seconds_in = item.second;
            time_tenths_in  = item.tenth;
         end
         CMD_SET_ALARM: begin
            alarm_hours_in   = item.hour;
            alarm_minutes_in = item.minute;
            alarm_seconds_in = item.second;
            alarm_tenths_in  = item.tenth;
         end
         CMD_PIN_SAMPLE: begin
            prev_pin_in = item.pin_level;
            if (prev_pin_ff && !item.pin_level) begin
               raise = FLAG_SOURCE;
            end
         end
         default: begin
            raise = '0;
         end
      endcase

      raise    = raise & cfg.interrupt_mask;
      flags_in = flags_ff | raise;

      hour_digits   = to_bcd({1'b0, time_hours_in});
      minute_digits = to_bcd(time_minutes_in);
      second_digits = to_bcd(time_seconds_in);
      tenth_digits  = to_bcd({2'b00, time_tenths_in});

      result.hour_bcd      = hour_digits[5:0];
      result.minute_bcd    = minute_digits;
      result.second_bcd    = second_digits;
      result.tenth_bcd     = tenth_digits[4:0];
      result.pending_flags = flags_in;
      result.irq           = |raise;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_hours_ff    <= '0;
         time_minutes_ff  <= '0;
         time_seconds_ff  <= '0;
         time_tenths_ff   <= '0;
         alarm_hours_ff   <= '0;
         alarm_minutes_ff <= '0;
         alarm_seconds_ff <= '0;
         alarm_tenths_ff  <= '0;
         flags_ff         <= '0;
         prev_pin_ff      <= 1'b1;
      end else if (step) begin
         time_hours_ff    <= time_hours_in;
         time_minutes_ff  <= time_minutes_in;
         time_seconds_ff  <= time_seconds_in;
         time_tenths_ff   <= time_tenths_in;
         alarm_hours_ff   <= alarm_hours_in;
         alarm_minutes_ff <= alarm_minutes_in;
         alarm_seconds_ff <= alarm_seconds_in;
         alarm_tenths_ff  <= alarm_tenths_in;
         flags_ff         <= flags_in;
         prev_pin_ff      <= prev_pin_in;
      end
   end

   `TOD_ASSERT_SAME(a_irq_has_flag, clock, reset, step && result.irq, result.pending_flags != '0, "irq without a pending flag")
   `TOD_ASSERT_NEXT(a_flags_sticky, clock, reset, 1'b1, (flags_ff & $past(flags_ff)) == $past(flags_ff), "pending flag cleared")
   `TOD_ASSERT_NEXT(a_tick_tenths, clock, reset, step && item.command == CMD_TICK, time_tenths_ff < 4'd10, "tenths out of range after tick")

endmodule

`default_nettype wire

>>> src/bcd_time_of_day_clock_with_alarm_irq.sv
// Top level of the BCD time-of-day clock with alarm and flag-pin interrupts.
//
// Usage: each req transaction carries one command in req_tuser (tick, set time,
// set alarm, flag-pin sample) and the time fields or pin level in req_tdata.
// Every command yields exactly one rsp transaction with the time after the
// command in BCD, the latched interrupt flags, and irq in rsp_tuser when the
// command latched a masked-in source bit.
// The csr channel writes register 0 (alarm enable) and register 1 (interrupt
// mask); it is always ready and should be used only while the block is idle.
// An accepted req transaction waits in the input register while the tick carry
// chain, alarm compare and BCD conversion settle, and its result is then taken
// into the result register, which drives the rsp transaction. Throughput is one
// transaction per cycle when rsp_tready is held high. When the receiver stalls,
// the result register holds and one more transaction is taken into the input
// register before req_tready drops.
// Reset clears the time, alarm, flags and configuration and sets the sampled
// pin high; no transaction is in flight afterwards.
`timescale 1ns / 1ps
`default_nettype none

module bcd_time_of_day_clock_with_alarm_irq (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [4:0] hour, [10:5] minute, [16:11] second, [20:17] tenth, [21] pin_level
   input  wire logic [23:0] req_tdata,
   // [1:0] command
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [5:0] hour_bcd, [12:6] minute_bcd, [19:13] second_bcd, [24:20] tenth_bcd,
   // [29:25] pending_flags
   output logic [31:0]      rsp_tdata,
   // [0] irq
   output logic             rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [4:0]  csr_data
);
   import tod_pkg::*;

   item_type   in_item_ff, in_item_in;
   logic       in_valid_ff, in_valid_in;
   result_type out_result_ff, out_result_in;
   logic       out_valid_ff, out_valid_in;
   result_type core_result;
   cfg_type    cfg;
   logic       advance;
   logic       req_take;

   tod_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tod_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   // The input register drains whenever the result register is empty or being emptied.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_item_in.command   = command_type'(req_tuser);
      in_item_in.hour      = req_tdata[4:0];
      in_item_in.minute    = req_tdata[10:5];
      in_item_in.second    = req_tdata[16:11];
      in_item_in.tenth     = req_tdata[20:17];
      in_item_in.pin_level = req_tdata[21];

      priority if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      out_result_in = core_result;
      priority if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         out_result_ff <= out_result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00,
                        out_result_ff.pending_flags,
                        out_result_ff.tenth_bcd,
                        out_result_ff.second_bcd,
                        out_result_ff.minute_bcd,
                        out_result_ff.hour_bcd};
   assign rsp_tuser  = out_result_ff.irq;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench of the BCD time-of-day clock with alarm and flag-pin interrupts.
`timescale 1ns / 1ps

import tod_pkg::*;

class tod_scoreboard;
   logic [4:0] hours;
   logic [5:0] minutes;
   logic [5:0] seconds;
   logic [3:0] tenths;
   logic [4:0] alarm_hours;
   logic [5:0] alarm_minutes;
   logic [5:0] alarm_seconds;
   logic [3:0] alarm_tenths;
   logic [FLAG_COUNT-1:0] latched;
   logic prev_pin;
   logic alarm_on;
   logic [FLAG_COUNT-1:0] irq_mask;
   result_type expected_results[$];
   int unsigned mismatch_count;

   function new();
      hours = '0;
      minutes = '0;
      seconds = '0;
      tenths = '0;
      alarm_hours = '0;
      alarm_minutes = '0;
      alarm_seconds = '0;
      alarm_tenths = '0;
      latched = '0;
      prev_pin = 1'b1;
      alarm_on = 1'b0;
      irq_mask = '0;
      mismatch_count = 0;
   endfunction

   function int unsigned pending();
      return expected_results.size();
   endfunction

   function void write_register(reg_index_type idx, logic [4:0] value);
      case (idx)
         REG_ALARM_ENABLE:   alarm_on = value[0];
         REG_INTERRUPT_MASK: irq_mask = value;
         default: ;
      endcase
   endfunction

   function logic [7:0] bcd_of(int unsigned v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function bit latch_source(logic [FLAG_COUNT-1:0] src);
      if ((irq_mask & src) != 0) begin
         latched = latched | src;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advances the clock state by one command and returns the time and flags after it.
   function result_type advance_time_of_day(item_type it);
      result_type r;
      int unsigned nt, ns, nm, nh;
      bit fired;
      fired = 1'b0;
      case (it.command)
         CMD_TICK: begin
            nt = tenths + 1;
            if (nt >= 10) begin
               nt = 0;
               ns = seconds + 1;
               if (ns >= 60) begin
                  ns = 0;
                  nm = minutes + 1;
                  if (nm >= 60) begin
                     nm = 0;
                     nh = hours + 1;
                     if (nh >= 24) begin
                        nh = 0;
                     end
                     hours = 5'(nh);
                  end
                  minutes = 6'(nm);
               end
               seconds = 6'(ns);
            end
            tenths = 4'(nt);
            if (alarm_on && hours == alarm_hours && minutes == alarm_minutes &&
                seconds == alarm_seconds && tenths == alarm_tenths) begin
               fired = latch_source(ALARM_SOURCE);
            end
         end
         CMD_SET_TIME: begin
            hours = it.hour;
            minutes = it.minute;
            seconds = it.second;
            tenths = it.tenth;
         end
         CMD_SET_ALARM: begin
            alarm_hours = it.hour;
            alarm_minutes = it.minute;
            alarm_seconds = it.second;
            alarm_tenths = it.tenth;
         end
         default: begin
            // Only a falling edge of the sampled pin raises the flag source.
            if (prev_pin && !it.pin_level) begin
               fired = latch_source(FLAG_SOURCE);
            end
            prev_pin = it.pin_level;
         end
      endcase
      r.hour_bcd = 6'(bcd_of(hours));
      r.minute_bcd = 7'(bcd_of(minutes));
      r.second_bcd = 7'(bcd_of(seconds));
      r.tenth_bcd = 5'(bcd_of(tenths));
      r.pending_flags = latched;
      r.irq = fired;
      return r;
   endfunction

   function void note_item(item_type it);
      expected_results.push_back(advance_time_of_day(it));
   endfunction

   function void check_result(result_type got);
      result_type want;
      if (expected_results.size() == 0) begin
         $error("result transaction arrived with nothing expected: %h", got);
         mismatch_count++;
         return;
      end
      want = expected_results.pop_front();
      if (got.hour_bcd !== want.hour_bcd) begin
         $error("hour_bcd: expected %h, got %h", want.hour_bcd, got.hour_bcd);
         mismatch_count++;
      end
      if (got.minute_bcd !== want.minute_bcd) begin
         $error("minute_bcd: expected %h, got %h", want.minute_bcd, got.minute_bcd);
         mismatch_count++;
      end
      if (got.second_bcd !== want.second_bcd) begin
         $error("second_bcd: expected %h, got %h", want.second_bcd, got.second_bcd);
         mismatch_count++;
      end
      if (got.tenth_bcd !== want.tenth_bcd) begin
         $error("tenth_bcd: expected %h, got %h", want.tenth_bcd, got.tenth_bcd);
         mismatch_count++;
      end
      if (got.pending_flags !== want.pending_flags) begin
         $error("pending_flags: expected %h, got %h", want.pending_flags, got.pending_flags);
         mismatch_count++;
      end
      if (got.irq !== want.irq) begin
         $error("irq: expected %b, got %b", want.irq, got.irq);
         mismatch_count++;
      end
   endfunction
endclass

module tb_top;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [4:0] csr_data = '0;

   tod_scoreboard sb = new();
   int unsigned items_sent = 0;
   int unsigned send_calm = 0;

   bcd_time_of_day_clock_with_alarm_irq uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Every handshake is observed here, at the edge where it takes place.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.write_register(reg_index_type'(csr_index), csr_data);
         end
         if (req_tvalid && req_tready) begin
            sb.note_item(item_type'({req_tuser, req_tdata[4:0], req_tdata[10:5],
                                     req_tdata[16:11], req_tdata[20:17], req_tdata[21]}));
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(result_type'({rsp_tdata[5:0], rsp_tdata[12:6], rsp_tdata[19:13],
                                          rsp_tdata[24:20], rsp_tdata[29:25], rsp_tuser}));
         end
      end
   end

   // The receiver stalls for a random count before each transaction, now and then
   // runs without stalls, and once holds off long enough for the block to fill up.
   initial begin : receiver
      int unsigned hold, calm, taken;
      calm = 0;
      taken = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (taken == 300) begin
            hold = 400;
         end else if (calm != 0) begin
            hold = 0;
            calm--;
         end else begin
            if ($urandom_range(0, 24) == 0) begin
               calm = 30;
            end
            hold = $urandom_range(0, 19);
         end
         if (hold != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   function automatic item_type random_item(command_type c);
      item_type it;
      it = item_type'(24'($urandom));
      it.command = c;
      return it;
   endfunction

   function automatic item_type time_item(command_type c, int unsigned h, int unsigned m,
                                          int unsigned s, int unsigned t);
      item_type it;
      it = random_item(c);
      it.hour = 5'(h);
      it.minute = 6'(m);
      it.second = 6'(s);
      it.tenth = 4'(t);
      return it;
   endfunction

   function automatic item_type pin_item(logic level);
      item_type it;
      it = random_item(CMD_PIN_SAMPLE);
      it.pin_level = level;
      return it;
   endfunction

   // Entered at a clock edge; leaves at the edge where the transaction is taken.
   task automatic send_item(input item_type it);
      int unsigned gap;
      if (send_calm != 0) begin
         gap = 0;
         send_calm--;
      end else begin
         if ($urandom_range(0, 24) == 0) begin
            send_calm = 30;
         end
         gap = $urandom_range(0, 19);
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, it.pin_level, it.tenth, it.second, it.minute, it.hour};
      req_tuser <= it.command;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic configure(input logic enable, input logic [4:0] mask);
      csr_valid <= 1'b1;
      csr_index <= REG_ALARM_ENABLE;
      csr_data <= {4'($urandom), enable};
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_INTERRUPT_MASK;
      csr_data <= mask;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed runs that reach alarm matches, carries and pin edges,
   // with some fully random transactions mixed in.
   task automatic send_random_sequence();
      int unsigned pick, k, h, m, s, t;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: begin
            h = $urandom_range(0, 23);
            m = $urandom_range(0, 59);
            s = $urandom_range(0, 59);
            t = $urandom_range(3, 9);
            k = $urandom_range(1, 3);
            send_item(time_item(CMD_SET_ALARM, h, m, s, t));
            send_item(time_item(CMD_SET_TIME, h, m, s, t - k));
            repeat (k + 1) send_item(random_item(CMD_TICK));
         end
         3, 4: begin
            h = $urandom_range(0, 31);
            m = $urandom_range(0, 1) ? 59 : $urandom_range(0, 63);
            s = $urandom_range(0, 1) ? 59 : $urandom_range(0, 63);
            t = $urandom_range(7, 15);
            send_item(time_item(CMD_SET_TIME, h, m, s, t));
            repeat ($urandom_range(1, 4)) send_item(random_item(CMD_TICK));
         end
         5, 6: begin
            repeat ($urandom_range(2, 6)) send_item(pin_item(1'($urandom)));
         end
         7: begin
            repeat ($urandom_range(3, 10)) send_item(random_item(CMD_TICK));
         end
         default: begin
            send_item(random_item(command_type'($urandom_range(0, 3))));
         end
      endcase
   endtask

   initial begin : stimulus
      int unsigned phase, target;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      configure(1'b1, 5'h1F);
      send_item(random_item(CMD_TICK));
      send_item(time_item(CMD_SET_ALARM, 0, 0, 0, 0));
      // Midnight rollover lands on the alarm.
      send_item(time_item(CMD_SET_TIME, 23, 59, 59, 9));
      send_item(random_item(CMD_TICK));
      // Out-of-range digits all carry and wrap; the alarm matches again.
      send_item(time_item(CMD_SET_TIME, 31, 63, 63, 15));
      send_item(random_item(CMD_TICK));
      // Out-of-range digits that receive no carry keep their value.
      send_item(time_item(CMD_SET_TIME, 31, 63, 63, 5));
      send_item(random_item(CMD_TICK));
      send_item(time_item(CMD_SET_TIME, 20, 63, 59, 9));
      send_item(random_item(CMD_TICK));
      // Setting the time onto the alarm does not compare.
      send_item(time_item(CMD_SET_ALARM, 31, 63, 63, 15));
      send_item(time_item(CMD_SET_TIME, 31, 63, 63, 15));
      send_item(random_item(CMD_TICK));
      send_item(pin_item(1'b1));
      send_item(pin_item(1'b0));
      send_item(pin_item(1'b0));
      send_item(pin_item(1'b1));
      send_item(pin_item(1'b0));
      send_item(time_item(CMD_SET_TIME, 10, 30, 45, 8));
      send_item(pin_item(1'b0));
      send_item(pin_item(1'b1));
      send_item(time_item(CMD_SET_ALARM, 10, 30, 45, 9));
      send_item(random_item(CMD_TICK));

      for (phase = 0; phase < 7; phase++) begin
         wait_for_drain();
         case (phase)
            0: configure(1'b0, 5'h1F);
            1: configure(1'b1, 5'h00);
            2: configure(1'b1, ALARM_SOURCE);
            3: configure(1'b1, FLAG_SOURCE);
            4: configure(1'b0, 5'h00);
            5: configure(1'b1, 5'h1F);
            default: configure(1'($urandom), 5'($urandom));
         endcase
         target = items_sent + 125;
         while (items_sent < target) send_random_sequence();
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

>>> files.f
+incdir+src
src/tod_pkg.sv
src/tod_csr.sv
src/tod_core.sv
src/bcd_time_of_day_clock_with_alarm_irq.sv
dv/tb_top.sv
